/* rtl/lifo_stack_with_sorted_readout_macros.svh */
// assertion macros of the lifo stack datapath
`ifndef LIFO_STACK_WITH_SORTED_READOUT_MACROS_SVH
`define LIFO_STACK_WITH_SORTED_READOUT_MACROS_SVH
`ifndef SYNTHESIS
`define LSR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lifo stack: same-cycle check failed");
`define LSR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lifo stack: next-cycle check failed");
`else
`define LSR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LSR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/lsr_pkg.sv */
// types and constants of the lifo stack with sorted readout
`timescale 1ns / 1ps
package lsr_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int VALUE_W   = 32;
  localparam int FIELD_W   = 6;
  localparam int ACT_W     = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_SUM     = 3'd3,
    ACT_READOUT = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_MEM,
    SEL_SUM,
    SEL_BEST
  } sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RESP,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic latch;
    logic push;
    logic pop;
    logic peek;
    logic scan_init;
    logic scan_step;
    logic resp;
    logic pop_sum;
    logic emit;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    status_t          chk;
    status_t          res_st;
    logic             scan_done;
    logic             sort_last;
  } stat_t;

endpackage

/* rtl/lsr_ctrl.sv */
// controller state machine of the lifo stack
`timescale 1ns / 1ps
module lsr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lsr_pkg::stat_t stat,
  output lsr_pkg::cmd_t  cmd
);
  import lsr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.act == ACT_READOUT && stat.chk == ST_OK) state_next = S_SCAN;
        else state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.sort_last) state_next = S_IDLE;
        else state_next = S_SCAN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECODE: begin
        cmd.latch = 1'b1;
        if (stat.chk == ST_OK) begin
          unique case (stat.act)
            ACT_PUSH:    cmd.push      = 1'b1;
            ACT_POP:     cmd.pop       = 1'b1;
            ACT_PEEK:    cmd.peek      = 1'b1;
            ACT_READOUT: cmd.scan_init = 1'b1;
            default:     cmd.push      = 1'b0;
          endcase
        end
      end
      S_RESP: begin
        cmd.resp = 1'b1;
        if (stat.res_st == ST_OK) begin
          unique case (stat.act)
            ACT_POP: begin
              cmd.sel     = SEL_MEM;
              cmd.pop_sum = 1'b1;
            end
            ACT_PEEK: cmd.sel = SEL_MEM;
            ACT_SUM:  cmd.sel = SEL_SUM;
            default:  cmd.sel = SEL_ZERO;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = !stat.scan_done;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_BEST;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/lsr_dpath.sv */
// datapath of the lifo stack: entry memory, counters, sum and readout scan
`timescale 1ns / 1ps
`include "lifo_stack_with_sorted_readout_macros.svh"
module lsr_dpath #(
  parameter int DEPTH = lsr_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lsr_pkg::ACT_W-1:0]           action,
  input  logic signed [lsr_pkg::VALUE_W-1:0]  value,
  input  logic [lsr_pkg::FIELD_W-1:0]         offset,
  input  logic [lsr_pkg::FIELD_W-1:0]         count,
  input  lsr_pkg::cmd_t                       cmd,
  output lsr_pkg::stat_t                      stat,
  output logic                                strobe,
  output logic signed [lsr_pkg::VALUE_W-1:0]  data,
  output logic [lsr_pkg::FIELD_W-1:0]         depth,
  output logic [lsr_pkg::STATUS_W-1:0]        status,
  output logic                                last
);
  import lsr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;

  logic [ACT_W-1:0]          act_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [FIELD_W-1:0]        offset_q;
  logic [FIELD_W-1:0]        count_q;

  logic [CW-1:0]             top_count;
  logic signed [VALUE_W-1:0] running_sum;
  status_t                   res_st;
  status_t                   chk;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic [AW-1:0]             rd_addr;
  logic                      rd_en;

  logic                      rd_vld;
  logic [AW-1:0]             rd_idx;
  logic [CW-1:0]             issue_idx;
  logic [CW-1:0]             emitted;
  logic signed [VALUE_W-1:0] prev_val;
  logic [AW-1:0]             prev_idx;
  logic                      have_prev;
  logic signed [VALUE_W-1:0] best_val;
  logic [AW-1:0]             best_idx;
  logic                      best_found;

  logic [CW-1:0]             top_m1;
  logic [XW-1:0]             peek_diff;
  logic                      issue_end;
  logic                      cand_after;
  logic                      cand_better;
  logic                      sort_last;
  logic signed [VALUE_W-1:0] out_sel;

  assign top_m1    = top_count - CW'(1);
  assign peek_diff = XW'(top_count) - XW'(offset_q);
  assign issue_end = (XW'(issue_idx) == XW'(count_q));
  assign sort_last = ((XW'(emitted) + XW'(1)) == XW'(count_q));

  // refusal check on the captured beat
  always_comb begin
    priority if (act_q == ACT_PUSH && top_count == CW'(DEPTH)) begin
      chk = ST_FULL;
    end else if ((act_q == ACT_POP || act_q == ACT_PEEK) && top_count == '0) begin
      chk = ST_EMPTY;
    end else if (act_q == ACT_PEEK &&
                 (offset_q == '0 || XW'(offset_q) > XW'(top_count))) begin
      chk = ST_RANGE;
    end else if (act_q == ACT_READOUT &&
                 (count_q == '0 || XW'(count_q) > XW'(top_count))) begin
      chk = ST_RANGE;
    end else begin
      chk = ST_OK;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_idx[AW-1:0];
    priority if (cmd.pop) begin
      rd_en   = 1'b1;
      rd_addr = top_m1[AW-1:0];
    end else if (cmd.peek) begin
      rd_en   = 1'b1;
      rd_addr = peek_diff[AW-1:0];
    end else if (cmd.scan_step && !issue_end) begin
      rd_en   = 1'b1;
    end else begin
      rd_en   = 1'b0;
    end
  end

  // next entry in descending order: after prev, ties broken by lower index
  assign cand_after  = !have_prev || (rd_data < prev_val) ||
                       (rd_data == prev_val && rd_idx > prev_idx);
  assign cand_better = !best_found || (rd_data > best_val);

  always_comb begin
    unique case (cmd.sel)
      SEL_ZERO: out_sel = '0;
      SEL_MEM:  out_sel = rd_data;
      SEL_SUM:  out_sel = running_sum;
      SEL_BEST: out_sel = best_val;
      default:  out_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[top_count[AW-1:0]] <= value_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count   <= '0;
      running_sum <= '0;
      rd_vld      <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe <= cmd.resp || cmd.emit;
      if (cmd.push) begin
        top_count   <= top_count + CW'(1);
        running_sum <= running_sum + value_q;
      end else if (cmd.pop) begin
        top_count <= top_m1;
      end
      if (cmd.pop_sum) begin
        running_sum <= running_sum - rd_data;
      end
      if (cmd.scan_init) begin
        rd_vld <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld <= !issue_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q    <= action;
      value_q  <= value;
      offset_q <= offset;
      count_q  <= count;
    end
    if (cmd.latch) begin
      res_st <= chk;
    end
    if (cmd.scan_init) begin
      issue_idx  <= '0;
      emitted    <= '0;
      have_prev  <= 1'b0;
      best_found <= 1'b0;
    end else if (cmd.emit) begin
      issue_idx  <= '0;
      emitted    <= emitted + CW'(1);
      have_prev  <= 1'b1;
      prev_val   <= best_val;
      prev_idx   <= best_idx;
      best_found <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!issue_end) begin
        issue_idx <= issue_idx + CW'(1);
        rd_idx    <= issue_idx[AW-1:0];
      end
      if (rd_vld && cand_after && cand_better) begin
        best_val   <= rd_data;
        best_idx   <= rd_idx;
        best_found <= 1'b1;
      end
    end
    if (cmd.resp || cmd.emit) begin
      data   <= out_sel;
      depth  <= FIELD_W'(top_count);
      status <= cmd.emit ? ST_OK : res_st;
      last   <= cmd.emit ? sort_last : 1'b1;
    end
  end

  assign stat.act       = act_q;
  assign stat.chk       = chk;
  assign stat.res_st    = res_st;
  assign stat.scan_done = issue_end && !rd_vld;
  assign stat.sort_last = sort_last;

  `LSR_ASSERT_IMP(a_top_bound, clk, rst, 1'b1, top_count <= CW'(DEPTH))
  `LSR_ASSERT_NXT(a_push_grows, clk, rst, cmd.push, top_count == $past(top_count) + CW'(1))
  `LSR_ASSERT_IMP(a_strobe_src, clk, rst, strobe, $past(cmd.resp || cmd.emit))
  `LSR_ASSERT_IMP(a_sorted_desc, clk, rst, cmd.emit && have_prev, best_val <= prev_val)

endmodule

/* rtl/lifo_stack_with_sorted_readout.sv */
// top level of the lifo stack with sorted readout
`timescale 1ns / 1ps
// Bounded LIFO stack of signed 32-bit words, DEPTH entries deep.
// A command beat is taken at a rising edge with start high and busy low; it
// carries action (push, pop, peek, sum query, sorted readout), value, offset
// and count. Each result beat sits on data, depth, status and last for one
// cycle with strobe high; the receiver cannot stall, so results never wait.
// Push, pop, peek, sum query and refused or unused actions give one result:
// the command passes the decode and response states, strobe is registered
// from the response state, and busy stays high until the block is idle again.
// A sorted readout of n bottom entries gives n results, largest first, last
// set on the final one. Each result is found by a scan through the n entries
// over the single read port of the entry memory, busy high throughout.
// Reset (rst, synchronous) empties the stack and clears the running sum.
// Entry contents are not cleared; only entries below the top are ever read.
module lifo_stack_with_sorted_readout #(
  parameter int DEPTH = lsr_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lsr_pkg::ACT_W-1:0]           action,
  input  logic signed [lsr_pkg::VALUE_W-1:0]  value,
  input  logic [lsr_pkg::FIELD_W-1:0]         offset,
  input  logic [lsr_pkg::FIELD_W-1:0]         count,
  output logic                                strobe,
  output logic signed [lsr_pkg::VALUE_W-1:0]  data,
  output logic [lsr_pkg::FIELD_W-1:0]         depth,
  output logic [lsr_pkg::STATUS_W-1:0]        status,
  output logic                                last
);
  import lsr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lsr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lsr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .action (action),
    .value  (value),
    .offset (offset),
    .count  (count),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .data   (data),
    .depth  (depth),
    .status (status),
    .last   (last)
  );

endmodule

/* tb/sv/lifo_stack_with_sorted_readout_tb.sv */
// testbench of the lifo stack: directed and random beats checked against a stack predictor
`timescale 1ns / 1ps
module lifo_stack_with_sorted_readout_tb;
  import lsr_pkg::*;

  localparam int STACK_DEPTH  = DEPTH_DEF;
  localparam int RANDOM_BEATS = 86;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef logic signed [VALUE_W-1:0] word_t;

  typedef struct packed {
    word_t              data;
    logic [FIELD_W-1:0] depth;
    status_t            status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    word_t              val;
    logic [FIELD_W-1:0] off;
    logic [FIELD_W-1:0] cnt;
    logic               typed;
    result_t            res;
  } cmd_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [ACT_W-1:0]   action;
  word_t              value;
  logic [FIELD_W-1:0] offset;
  logic [FIELD_W-1:0] count;
  logic               strobe;
  word_t              data;
  logic [FIELD_W-1:0] depth;
  logic [STATUS_W-1:0] status;
  logic               last;

  // stack predictor state
  word_t   stack_mem [STACK_DEPTH];
  int      stack_fill;
  word_t   stack_sum;
  result_t step_results [$];
  result_t expected_results [$];

  cmd_row_t    directed_cmds [$];
  int          idle_pct;
  int          mismatch_count;
  int unsigned cycle_count;

  lifo_stack_with_sorted_readout u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .action (action),
    .value  (value),
    .offset (offset),
    .count  (count),
    .strobe (strobe),
    .data   (data),
    .depth  (depth),
    .status (status),
    .last   (last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic result_t outcome(input word_t d, input status_t st, input logic lst);
    result_t r;
    r.data   = d;
    r.depth  = stack_fill[FIELD_W-1:0];
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  function automatic cmd_row_t row(input logic [ACT_W-1:0] act, input word_t val,
                                   input logic [FIELD_W-1:0] off, input logic [FIELD_W-1:0] cnt,
                                   input logic typed, input word_t d,
                                   input logic [FIELD_W-1:0] dep, input status_t st);
    cmd_row_t c;
    c.act        = act;
    c.val        = val;
    c.off        = off;
    c.cnt        = cnt;
    c.typed      = typed;
    c.res.data   = d;
    c.res.depth  = dep;
    c.res.status = st;
    c.res.last   = 1'b1;
    return c;
  endfunction

  // apply one command to the predicted stack, results go to step_results
  function automatic void stack_apply(input logic [ACT_W-1:0] act, input word_t val,
                                      input logic [FIELD_W-1:0] off,
                                      input logic [FIELD_W-1:0] cnt);
    word_t sorted [STACK_DEPTH];
    word_t key;
    int    i;
    int    j;
    step_results.delete();
    case (act)
      ACT_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          step_results.push_back(outcome('0, ST_FULL, 1'b1));
        end else begin
          stack_mem[stack_fill] = val;
          stack_fill++;
          stack_sum += val;
          step_results.push_back(outcome('0, ST_OK, 1'b1));
        end
      end
      ACT_POP: begin
        if (stack_fill == 0) begin
          step_results.push_back(outcome('0, ST_EMPTY, 1'b1));
        end else begin
          stack_fill--;
          stack_sum -= stack_mem[stack_fill];
          step_results.push_back(outcome(stack_mem[stack_fill], ST_OK, 1'b1));
        end
      end
      ACT_PEEK: begin
        if (stack_fill == 0)
          step_results.push_back(outcome('0, ST_EMPTY, 1'b1));
        else if (off == 0 || off > stack_fill)
          step_results.push_back(outcome('0, ST_RANGE, 1'b1));
        else
          step_results.push_back(outcome(stack_mem[stack_fill - off], ST_OK, 1'b1));
      end
      ACT_SUM: step_results.push_back(outcome(stack_sum, ST_OK, 1'b1));
      ACT_READOUT: begin
        if (cnt == 0 || cnt > stack_fill) begin
          step_results.push_back(outcome('0, ST_RANGE, 1'b1));
        end else begin
          for (i = 0; i < cnt; i++)
            sorted[i] = stack_mem[i];
          // descending insertion sort, signed compare
          for (i = 1; i < cnt; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] < key) begin
              sorted[j] = sorted[j-1];
              j--;
            end
            sorted[j] = key;
          end
          for (i = 0; i < cnt; i++)
            step_results.push_back(outcome(sorted[i], ST_OK, i == cnt - 1));
        end
      end
      default: step_results.push_back(outcome('0, ST_OK, 1'b1));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_cmd(input logic [ACT_W-1:0] act, input word_t val,
                          input logic [FIELD_W-1:0] off, input logic [FIELD_W-1:0] cnt,
                          input logic typed, input result_t res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start  <= 1'b1;
    action <= act;
    value  <= val;
    offset <= off;
    count  <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    stack_apply(act, val, off, cnt);
    if (typed)
      expected_results.push_back(res);
    else
      foreach (step_results[k]) expected_results.push_back(step_results[k]);
    @(negedge clk);
  endtask

  task automatic wait_drained;
    while (expected_results.size() != 0) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat: expected none, actual %0d/%0d/%0d/%0d",
                 $time, data, depth, status, last);
      end else begin
        want = expected_results.pop_front();
        if (data !== want.data) begin
          mismatch_count++;
          $display("%0t: data mismatch: expected %0d, actual %0d", $time, want.data, data);
        end
        if (depth !== want.depth) begin
          mismatch_count++;
          $display("%0t: depth mismatch: expected %0d, actual %0d", $time, want.depth, depth);
        end
        if (status !== want.status) begin
          mismatch_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, status);
        end
        if (last !== want.last) begin
          mismatch_count++;
          $display("%0t: last mismatch: expected %0d, actual %0d", $time, want.last, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int                 n;
    int                 push_pct;
    int                 pick;
    int                 cnt_cap;
    logic [ACT_W-1:0]   act;
    word_t              val;
    logic [FIELD_W-1:0] off;
    logic [FIELD_W-1:0] cnt;
    rst            = 1'b1;
    start          = 1'b0;
    action         = ACT_PUSH;
    value          = '0;
    offset         = '0;
    count          = '0;
    idle_pct       = 26;
    mismatch_count = 0;
    cycle_count    = 0;
    stack_fill     = 0;
    stack_sum      = '0;
    directed_cmds = '{
      row(ACT_SUM,      0,        1,  1,  1'b1, 0,        0, ST_OK),
      row(ACT_POP,      0,        1,  1,  1'b1, 0,        0, ST_EMPTY),
      row(ACT_PEEK,     0,        1,  1,  1'b1, 0,        0, ST_EMPTY),
      row(ACT_READOUT,  0,        1,  1,  1'b1, 0,        0, ST_RANGE),
      row(ACT_SPARE_HI, -1,       63, 63, 1'b1, 0,        0, ST_OK),
      row(ACT_PUSH,     WORD_MAX, 0,  0,  1'b1, 0,        1, ST_OK),
      row(ACT_PUSH,     WORD_MIN, 0,  0,  1'b1, 0,        2, ST_OK),
      row(ACT_PUSH,     0,        0,  0,  1'b1, 0,        3, ST_OK),
      row(ACT_PUSH,     -1,       0,  0,  1'b1, 0,        4, ST_OK),
      row(ACT_PUSH,     5,        0,  0,  1'b1, 0,        5, ST_OK),
      row(ACT_SUM,      0,        0,  0,  1'b0, 0,        0, ST_OK),
      row(ACT_PEEK,     0,        0,  1,  1'b1, 0,        5, ST_RANGE),
      row(ACT_PEEK,     0,        6,  1,  1'b1, 0,        5, ST_RANGE),
      row(ACT_PEEK,     0,        63, 1,  1'b1, 0,        5, ST_RANGE),
      row(ACT_PEEK,     0,        1,  1,  1'b1, 5,        5, ST_OK),
      row(ACT_PEEK,     0,        5,  1,  1'b1, WORD_MAX, 5, ST_OK),
      row(ACT_READOUT,  0,        1,  0,  1'b1, 0,        5, ST_RANGE),
      row(ACT_READOUT,  0,        1,  6,  1'b1, 0,        5, ST_RANGE),
      row(ACT_READOUT,  0,        1,  5,  1'b0, 0,        0, ST_OK),
      row(ACT_READOUT,  0,        1,  1,  1'b0, 0,        0, ST_OK),
      row(ACT_SPARE_LO, 0,        0,  0,  1'b1, 0,        5, ST_OK),
      row(ACT_POP,      0,        1,  1,  1'b1, 5,        4, ST_OK),
      row(ACT_POP,      0,        1,  1,  1'b0, 0,        0, ST_OK),
      row(ACT_READOUT,  0,        1,  63, 1'b1, 0,        3, ST_RANGE)
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_cmds[k])
      send_cmd(directed_cmds[k].act, directed_cmds[k].val, directed_cmds[k].off,
               directed_cmds[k].cnt, directed_cmds[k].typed, directed_cmds[k].res);
    wait_drained();

    // fill to the top, overflow once, then a full-depth readout
    n = 0;
    while (stack_fill < STACK_DEPTH) begin
      send_cmd(ACT_PUSH, word_t'($urandom), '0, '0, 1'b0, '0);
      n++;
    end
    send_cmd(ACT_PUSH, word_t'($urandom), '0, '0, 1'b0, '0);
    send_cmd(ACT_READOUT, word_t'($urandom), '0, FIELD_W'(STACK_DEPTH), 1'b0, '0);
    n += 2;

    while (n < RANDOM_BEATS) begin
      if (n == 45 || n == 66)
        wait_drained();
      idle_pct = (n < 45) ? 26 : ((n < 66) ? 77 : 0);
      if ($urandom_range(99) < 3)
        wait_drained();
      act = ACT_PUSH;
      val = word_t'($urandom);
      off = FIELD_W'($urandom);
      cnt = FIELD_W'($urandom);
      pick = $urandom_range(9);
      if (pick == 0)
        val = WORD_MAX;
      else if (pick == 1)
        val = WORD_MIN;
      push_pct = (stack_fill > 24) ? 15 : 40;
      pick = $urandom_range(99);
      if (pick < push_pct) begin
        act = ACT_PUSH;
      end else if (pick < push_pct + 18) begin
        act = ACT_POP;
      end else if (pick < push_pct + 33) begin
        act = ACT_PEEK;
        if (stack_fill > 0 && $urandom_range(9) < 8)
          off = FIELD_W'($urandom_range(1, stack_fill));
      end else if (pick < push_pct + 43) begin
        act = ACT_SUM;
      end else if (pick < push_pct + 53) begin
        act = ACT_READOUT;
        if (stack_fill > 0 && $urandom_range(9) < 8) begin
          cnt_cap = ($urandom_range(9) == 0 || stack_fill < 6) ? stack_fill : 6;
          cnt = FIELD_W'($urandom_range(1, cnt_cap));
        end
      end else if ($urandom_range(1) == 0) begin
        act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end else begin
        act = ACT_W'($urandom);
      end
      send_cmd(act, val, off, cnt, 1'b0, '0);
      n++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lsr_pkg.sv
rtl/lsr_ctrl.sv
rtl/lsr_dpath.sv
rtl/lifo_stack_with_sorted_readout.sv
tb/sv/lifo_stack_with_sorted_readout_tb.sv
